// ===== sv/fvg_pkg.sv =====
`timescale 1ns / 1ps
package fvg_pkg;

    localparam int unsigned SecW   = 32;
    localparam int unsigned SpcW   = 7;
    localparam int unsigned FatW   = 20;
    localparam int unsigned DataW  = 21;
    localparam int unsigned ClustW = 27;
    localparam int unsigned DivW   = 14;
    localparam int unsigned ShW    = 3;
    localparam int unsigned DivSteps = FatW;

    localparam logic [SecW-1:0] MinSectors = 32'd66600;
    localparam logic [SecW-1:0] LimitSpc1  = 32'd532480;
    localparam logic [SecW-1:0] LimitSpc8  = 32'd16777216;
    localparam logic [SecW-1:0] LimitSpc16 = 32'd33554432;
    localparam logic [SecW-1:0] LimitSpc32 = 32'd67108864;
    localparam logic [SecW-1:0] Reserved   = 32'd32;

    typedef struct packed {
        logic             too_small;
        logic [SpcW-1:0]  spc;
        logic [ShW-1:0]   shift;
        logic [SecW-1:0]  sectors;
        logic [DivW-1:0]  divisor;
    } t_ctx;

    typedef struct packed {
        logic [DivW-1:0]  rem;
        logic [FatW-1:0]  word;
    } t_div;

endpackage

// ===== sv/fat32_volume_geometry_unit.sv =====
`timescale 1ns / 1ps
// Pipeline from input transaction to result: cluster-size select, 20 restoring
// divider steps for the FAT size, then layout and cluster count.
// Throughput: one transaction per cycle unless i_stall holds the output; each divider step is one pipeline stage.
// Bubbles collapse: a stage loads whenever it is empty or the next stage moves.
// Reset (synchronous, active low) clears all stage valid bits; no results pending.
module fat32_volume_geometry_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [fvg_pkg::SecW-1:0]      i_volume_sectors,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_too_small,
    output logic [fvg_pkg::SpcW-1:0]      o_sectors_per_cluster,
    output logic [fvg_pkg::FatW-1:0]      o_fat_size_sectors,
    output logic [fvg_pkg::DataW-1:0]     o_data_start_sector,
    output logic [fvg_pkg::ClustW-1:0]    o_data_clusters
);
    import fvg_pkg::*;

    logic               v   [0:DivSteps];
    t_ctx               ctx [0:DivSteps];
    t_div               dv  [0:DivSteps];
    logic               en  [0:DivSteps+1];
    logic               back_valid;

    assign en[DivSteps+1] = !back_valid || !i_stall;

    genvar k;
    generate
        for (k = 0; k <= DivSteps; k++) begin : g_en
            assign en[k] = !v[k] || en[k+1];
        end
    endgenerate

    assign o_stall = !en[0];

    fvg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en[0]),
        .i_valid          (i_valid),
        .i_volume_sectors (i_volume_sectors),
        .o_valid          (v[0]),
        .o_ctx            (ctx[0]),
        .o_div            (dv[0])
    );

    generate
        for (k = 0; k < DivSteps; k++) begin : g_step
            fvg_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en[k+1]),
                .i_valid (v[k]),
                .i_ctx   (ctx[k]),
                .i_div   (dv[k]),
                .o_valid (v[k+1]),
                .o_ctx   (ctx[k+1]),
                .o_div   (dv[k+1])
            );
        end
    endgenerate

    fvg_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (en[DivSteps+1]),
        .i_valid               (v[DivSteps]),
        .i_ctx                 (ctx[DivSteps]),
        .i_div                 (dv[DivSteps]),
        .o_valid               (back_valid),
        .o_too_small           (o_too_small),
        .o_sectors_per_cluster (o_sectors_per_cluster),
        .o_fat_size_sectors    (o_fat_size_sectors),
        .o_data_start_sector   (o_data_start_sector),
        .o_data_clusters       (o_data_clusters)
    );

    assign o_valid = back_valid;

endmodule

// ===== sv/fvg_front.sv =====
`timescale 1ns / 1ps
module fvg_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [fvg_pkg::SecW-1:0]     i_volume_sectors,
    output logic                         o_valid,
    output fvg_pkg::t_ctx                o_ctx,
    output fvg_pkg::t_div                o_div
);
    import fvg_pkg::*;

    t_ctx          n_ctx;
    t_div          n_div;
    logic [32:0]   dividend;
    logic          r_valid;
    t_ctx          r_ctx;
    t_div          r_div;

    always_comb begin
        n_ctx.sectors   = i_volume_sectors;
        n_ctx.too_small = (i_volume_sectors <= MinSectors);
        if (n_ctx.too_small) begin
            n_ctx.spc   = 7'd0;
            n_ctx.shift = 3'd0;
        end else if (i_volume_sectors <= LimitSpc1) begin
            n_ctx.spc   = 7'd1;
            n_ctx.shift = 3'd0;
        end else if (i_volume_sectors <= LimitSpc8) begin
            n_ctx.spc   = 7'd8;
            n_ctx.shift = 3'd3;
        end else if (i_volume_sectors <= LimitSpc16) begin
            n_ctx.spc   = 7'd16;
            n_ctx.shift = 3'd4;
        end else if (i_volume_sectors <= LimitSpc32) begin
            n_ctx.spc   = 7'd32;
            n_ctx.shift = 3'd5;
        end else begin
            n_ctx.spc   = 7'd64;
            n_ctx.shift = 3'd6;
        end
        n_ctx.divisor = {n_ctx.spc, 7'd1};
        if (n_ctx.too_small) begin
            dividend = 33'd0;
        end else begin
            dividend = {1'b0, i_volume_sectors} - {1'b0, Reserved}
                     + {19'd0, n_ctx.spc, 7'd0};
        end
        n_div.rem  = {1'b0, dividend[32:20]};
        n_div.word = dividend[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

endmodule

// ===== sv/fvg_div_step.sv =====
`timescale 1ns / 1ps
module fvg_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  fvg_pkg::t_ctx   i_ctx,
    input  fvg_pkg::t_div   i_div,
    output logic            o_valid,
    output fvg_pkg::t_ctx   o_ctx,
    output fvg_pkg::t_div   o_div
);
    import fvg_pkg::*;

    logic [DivW:0]  trial;
    logic           ge;
    logic [DivW:0]  diff;
    t_div           n_div;
    logic           r_valid;
    t_ctx           r_ctx;
    t_div           r_div;

    always_comb begin
        trial      = {i_div.rem, i_div.word[FatW-1]};
        ge         = (trial >= {1'b0, i_ctx.divisor});
        diff       = trial - {1'b0, i_ctx.divisor};
        n_div.rem  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
        n_div.word = {i_div.word[FatW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

endmodule

// ===== sv/fvg_back.sv =====
`timescale 1ns / 1ps
module fvg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  fvg_pkg::t_ctx                 i_ctx,
    input  fvg_pkg::t_div                 i_div,
    output logic                          o_valid,
    output logic                          o_too_small,
    output logic [fvg_pkg::SpcW-1:0]      o_sectors_per_cluster,
    output logic [fvg_pkg::FatW-1:0]      o_fat_size_sectors,
    output logic [fvg_pkg::DataW-1:0]     o_data_start_sector,
    output logic [fvg_pkg::ClustW-1:0]    o_data_clusters
);
    import fvg_pkg::*;

    logic [DataW-1:0]  data;
    logic [SecW-1:0]   rest;
    logic [SecW-1:0]   shifted;
    logic              r_valid;
    logic              r_too_small;
    logic [SpcW-1:0]   r_spc;
    logic [FatW-1:0]   r_fat;
    logic [DataW-1:0]  r_data;
    logic [ClustW-1:0] r_clust;

    always_comb begin
        data    = Reserved[DataW-1:0] + {i_div.word, 1'b0};
        rest    = i_ctx.sectors - {11'd0, data};
        shifted = rest >> i_ctx.shift;
        if (i_ctx.sectors < {11'd0, data}) begin
            shifted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_too_small <= i_ctx.too_small;
            if (i_ctx.too_small) begin
                r_spc   <= '0;
                r_fat   <= '0;
                r_data  <= '0;
                r_clust <= '0;
            end else begin
                r_spc   <= i_ctx.spc;
                r_fat   <= i_div.word;
                r_data  <= data;
                r_clust <= shifted[ClustW-1:0];
            end
        end
    end

    assign o_valid               = r_valid;
    assign o_too_small           = r_too_small;
    assign o_sectors_per_cluster = r_spc;
    assign o_fat_size_sectors    = r_fat;
    assign o_data_start_sector   = r_data;
    assign o_data_clusters       = r_clust;

endmodule
